// ===== src/three_level_priority_task_queue_defines.svh =====
// assertion macros used by the checker file
`ifndef THREE_LEVEL_PRIORITY_TASK_QUEUE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_TASK_QUEUE_DEFINES_SVH

// checked only outside reset
`define TPQ_ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tpq_pkg.sv =====
`default_nettype none

package tpq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int CODE_BITS_DEF   = 32;

   localparam int MODE_W   = 2;
   localparam int CODE_W   = 32;
   localparam int PRIO_W   = 2;
   localparam int STATUS_W = 2;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [PRIO_W-1:0]   prio_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_ENQ  = 2'd0;
   localparam mode_type MODE_DEQ  = 2'd1;
   localparam mode_type MODE_LIST = 2'd2;

   localparam prio_type PRIO_NONE = 2'd0;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_EMPTY    = 2'd1;
   localparam status_type STATUS_BAD_PRIO = 2'd2;
   localparam status_type STATUS_FULL     = 2'd3;

endpackage

`default_nettype wire

// ===== src/tpq_if.sv =====
`default_nettype none

interface tpq_req_if;
   logic                             valid;
   logic                             ready;
   tpq_pkg::mode_type                mode;
   logic signed [tpq_pkg::CODE_W-1:0] task_code;
   tpq_pkg::prio_type                priority_req;

   modport source (output valid, output mode, output task_code, output priority_req,
                   input ready);
   modport sink (input valid, input mode, input task_code, input priority_req,
                 output ready);
   modport monitor (input valid, input ready, input mode, input task_code,
                    input priority_req);
endinterface

interface tpq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [tpq_pkg::CODE_W-1:0] result_code;
   tpq_pkg::prio_type                result_priority;
   tpq_pkg::status_type              status;
   logic                             last;

   modport source (output valid, output result_code, output result_priority,
                   output status, output last, input ready);
   modport sink (input valid, input result_code, input result_priority,
                 input status, input last, output ready);
   modport monitor (input valid, input ready, input result_code, input result_priority,
                    input status, input last);
endinterface

`default_nettype wire

// ===== src/tpq_ram.sv =====
`default_nettype none

module tpq_ram #(
   parameter int WIDTH = tpq_pkg::CODE_BITS_DEF,
   parameter int DEPTH = 3 * tpq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/three_level_priority_task_queue.sv =====
// Three strict-priority task FIFOs (low, medium, high) sharing one storage RAM.
// req_chan takes items: mode enqueue, dequeue or list, a task code and a priority.
// rsp_chan returns results: code, priority, status and a last marker; every item
// except mode 3 gives at least one result, the final one with last set.
// Enqueue and refused/empty results: registered into the output register, or the
// hold register under a stall; a new item every cycle while rsp_chan keeps up.
// Dequeue: one RAM read, then the output register; no new item is taken meanwhile.
// List: one RAM read per stored entry, high queue first, each queue head to tail;
// req_chan.ready stays low until the last one.
// The shared RAM read port with its registered read data sets these steps.
// Reset clears head, tail and count registers at once; RAM contents stay as they
// are and are never read before written, so there is no clearing pass.
// A stalled rsp_chan holds its result in the output register; one further result
// parks in a hold register and req_chan.ready drops until the output drains.
`default_nettype none

module three_level_priority_task_queue #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
   parameter int CODE_BITS   = tpq_pkg::CODE_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   tpq_req_if.sink   req_chan,
   tpq_rsp_if.source rsp_chan
);

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = 3 * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   localparam logic [1:0] Q_LOW  = 2'd0;
   localparam logic [1:0] Q_MID  = 2'd1;
   localparam logic [1:0] Q_HIGH = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LREAD,
      S_LDATA,
      S_HOLD
   } state_type;

   typedef struct packed {
      logic signed [tpq_pkg::CODE_W-1:0] code;
      tpq_pkg::prio_type                 prio;
      tpq_pkg::status_type               status;
      logic                              last;
   } result_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] q,
                                                   input logic [PTR_W-1:0] p);
      logic [ADDR_W-1:0] base;
      case (q)
         Q_HIGH:  base = ADDR_W'(2 * QUEUE_DEPTH);
         Q_MID:   base = ADDR_W'(QUEUE_DEPTH);
         default: base = '0;
      endcase
      return base + ADDR_W'(p);
   endfunction

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
   endfunction

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff [3];
   logic [PTR_W-1:0] head_in [3];
   logic [PTR_W-1:0] tail_ff [3];
   logic [PTR_W-1:0] tail_in [3];
   logic [CNT_W-1:0] cnt_ff [3];
   logic [CNT_W-1:0] cnt_in [3];

   logic [1:0]       list_q_ff, list_q_in;
   logic [PTR_W-1:0] list_ptr_ff, list_ptr_in;
   logic [CNT_W-1:0] list_left_ff, list_left_in;
   tpq_pkg::prio_type item_prio_ff, item_prio_in;
   logic             item_last_ff, item_last_in;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;
   result_type       hold_ff, hold_in;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [CODE_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [CODE_BITS-1:0] mem_rdata;

   logic       req_acc;
   logic       out_free;
   logic       any_full_q;
   logic [1:0] top_q;
   logic [1:0] enq_q;
   logic       below_any;
   logic [1:0] below_q;
   logic       res_load;
   result_type res;

   tpq_ram #(
      .WIDTH (CODE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_tpq_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.result_code     = rsp_ff.code;
   assign rsp_chan.result_priority = rsp_ff.prio;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.last            = rsp_ff.last;

   // highest nonempty queue
   always_comb begin
      any_full_q = (cnt_ff[Q_HIGH] != '0) || (cnt_ff[Q_MID] != '0) || (cnt_ff[Q_LOW] != '0);
      if (cnt_ff[Q_HIGH] != '0) begin
         top_q = Q_HIGH;
      end else if (cnt_ff[Q_MID] != '0) begin
         top_q = Q_MID;
      end else begin
         top_q = Q_LOW;
      end
   end

   // next nonempty queue below the one being listed
   always_comb begin
      below_any = 1'b0;
      below_q   = Q_LOW;
      case (list_q_ff)
         Q_HIGH: begin
            if (cnt_ff[Q_MID] != '0) begin
               below_any = 1'b1;
               below_q   = Q_MID;
            end else if (cnt_ff[Q_LOW] != '0) begin
               below_any = 1'b1;
               below_q   = Q_LOW;
            end
         end
         Q_MID: begin
            if (cnt_ff[Q_LOW] != '0) begin
               below_any = 1'b1;
               below_q   = Q_LOW;
            end
         end
         default: ;
      endcase
   end

   assign enq_q = req_chan.priority_req - 2'd1;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      list_q_in    = list_q_ff;
      list_ptr_in  = list_ptr_ff;
      list_left_in = list_left_ff;
      item_prio_in = item_prio_ff;
      item_last_in = item_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;

      mem_we    = 1'b0;
      mem_waddr = slot_addr(enq_q, tail_ff[enq_q[0] ? Q_MID : (enq_q[1] ? Q_HIGH : Q_LOW)]);
      mem_wdata = CODE_BITS'(req_chan.task_code);
      mem_re    = 1'b0;
      mem_raddr = slot_addr(list_q_ff, list_ptr_ff);

      res_load   = 1'b0;
      res.code   = '0;
      res.prio   = tpq_pkg::PRIO_NONE;
      res.status = tpq_pkg::STATUS_OK;
      res.last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_chan.mode)
                  tpq_pkg::MODE_ENQ: begin
                     res_load = 1'b1;
                     if (req_chan.priority_req == tpq_pkg::PRIO_NONE) begin
                        res.status = tpq_pkg::STATUS_BAD_PRIO;
                     end else if (cnt_ff[enq_q] == FULL_CNT) begin
                        res.status = tpq_pkg::STATUS_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        mem_waddr      = slot_addr(enq_q, tail_ff[enq_q]);
                        tail_in[enq_q] = next_slot(tail_ff[enq_q]);
                        cnt_in[enq_q]  = cnt_ff[enq_q] + ONE_CNT;
                     end
                  end
                  tpq_pkg::MODE_DEQ: begin
                     if (any_full_q) begin
                        mem_re         = 1'b1;
                        mem_raddr      = slot_addr(top_q, head_ff[top_q]);
                        head_in[top_q] = next_slot(head_ff[top_q]);
                        cnt_in[top_q]  = cnt_ff[top_q] - ONE_CNT;
                        item_prio_in   = top_q + 2'd1;
                        item_last_in   = 1'b1;
                        state_in       = S_LDATA;
                     end else begin
                        res_load   = 1'b1;
                        res.status = tpq_pkg::STATUS_EMPTY;
                     end
                  end
                  tpq_pkg::MODE_LIST: begin
                     if (any_full_q) begin
                        list_q_in    = top_q;
                        list_ptr_in  = head_ff[top_q];
                        list_left_in = cnt_ff[top_q];
                        state_in     = S_LREAD;
                     end else begin
                        res_load   = 1'b1;
                        res.status = tpq_pkg::STATUS_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LREAD: begin
            mem_re       = 1'b1;
            item_prio_in = list_q_ff + 2'd1;
            item_last_in = (list_left_ff == ONE_CNT) && !below_any;
            if (list_left_ff != ONE_CNT) begin
               list_ptr_in  = next_slot(list_ptr_ff);
               list_left_in = list_left_ff - ONE_CNT;
            end else begin
               list_q_in    = below_q;
               list_ptr_in  = head_ff[below_q];
               list_left_in = cnt_ff[below_q];
            end
            state_in = S_LDATA;
         end
         S_LDATA: begin
            res_load   = 1'b1;
            res.code   = tpq_pkg::CODE_W'(mem_rdata);
            res.prio   = item_prio_ff;
            res.status = tpq_pkg::STATUS_OK;
            res.last   = item_last_ff;
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = hold_ff;
               state_in     = hold_ff.last ? S_IDLE : S_LREAD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (res_load) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = res.last ? S_IDLE : S_LREAD;
         end else begin
            hold_in  = res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         cnt_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      list_q_ff    <= list_q_in;
      list_ptr_ff  <= list_ptr_in;
      list_left_ff <= list_left_in;
      item_prio_ff <= item_prio_in;
      item_last_ff <= item_last_in;
      rsp_ff       <= rsp_in;
      hold_ff      <= hold_in;
   end

endmodule

`default_nettype wire

// ===== src/tpq_checker.sv =====
`default_nettype none

`include "three_level_priority_task_queue_defines.svh"

module tpq_checker (
   input wire logic  clock,
   input wire logic  reset,
   tpq_req_if.sink   req_chan,
   tpq_rsp_if.source rsp_chan
);

   // output register is empty right after reset
   `TPQ_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_chan.valid, "rsp valid after reset")

   // a stalled item keeps its payload
   `TPQ_ASSERT_SYNC(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.result_code) && $stable(rsp_chan.status) && $stable(rsp_chan.last), "rsp item changed under stall")

   // no new item while a list is still being sent
   `TPQ_ASSERT_SYNC(a_list_blocks_req, clock, reset, rsp_chan.valid && !rsp_chan.last |-> !req_chan.ready, "req ready during list")

   // refused or empty results carry no code
   `TPQ_ASSERT_SYNC(a_refusal_shape, clock, reset, rsp_chan.valid && (rsp_chan.status != tpq_pkg::STATUS_OK) |-> rsp_chan.last && (rsp_chan.result_code == 0) && (rsp_chan.result_priority == tpq_pkg::PRIO_NONE), "bad refusal result")

   // invalid priority answered at once when the output is free
   `TPQ_ASSERT_SYNC(a_bad_prio_resp, clock, reset, req_chan.valid && req_chan.ready && (req_chan.mode == tpq_pkg::MODE_ENQ) && (req_chan.priority_req == tpq_pkg::PRIO_NONE) && (!rsp_chan.valid || rsp_chan.ready) |=> rsp_chan.valid && (rsp_chan.status == tpq_pkg::STATUS_BAD_PRIO), "missing invalid priority result")

endmodule

bind three_level_priority_task_queue tpq_checker u_tpq_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

`default_nettype wire
